@@ hdl/dnsdec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsdec_pkg
// Shared widths, field codes and constants of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnsdec_pkg;

	// field widths
	localparam int OFFSET_W    = 10;
	localparam int BYTE_W      = 8;
	localparam int USED_W      = 11;
	localparam int STATUS_W    = 2;
	localparam int LABEL_W     = 6;
	localparam int JUMP_W      = 8;
	// walk position: a 14-bit pointer target plus one step of headroom
	localparam int POS_W       = 15;

	// packed beat widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// input kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TRUNC    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RESERVED = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_LOOP     = 2'd3;

	// message byte markers
	localparam logic [BYTE_W-1:0] PTR_MARK     = 8'hC0;
	localparam logic [BYTE_W-1:0] RESERVED_LOW = 8'h40;
	localparam logic [BYTE_W-1:0] DOT_CHAR     = 8'h2E;

	localparam logic [USED_W-1:0] USED_MAX     = 11'd2047;
	localparam logic [JUMP_W-1:0] JUMPS_RESET  = 8'd16;

endpackage

@@ hdl/dns_name_decompress_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_decompress_top
// DNS name decompressor: message byte store, label walker with pointer
// following, and a dotted-name character stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries load and decode beats (tuser = kind). A load beat writes
//   one message byte. A decode beat walks the name at byte_offset and sends
//   one m_axis beat per name character; the final beat has tlast set and
//   carries consumed and status. An empty name gives a single beat with
//   tuser (has_char) low. cfg_valid/cfg_data write max_pointer_jumps; do so
//   only while the block is idle (the block does not enforce this).
// Timing:
//   The store is a single-port memory with a registered read, and the walker
//   reads one message byte per cycle while the output is not stalled (length
//   bytes, label bytes, two bytes per pointer). Each character is held back
//   until the walker knows whether it is last, and is sent when the next
//   character pushes it out or with the final beat.
// Reset and stall:
//   Reset clears control state and sets max_pointer_jumps to 16; the store is
//   not cleared. A stalled m_axis holds the walker at the next character
//   until the output register frees up; one finished beat waits in it while
//   a new input beat can be accepted.
// ----------------------------------------------------------------------------
module dns_name_decompress_top #(
	parameter int STORE_BYTES = 1024,
	parameter int NAME_CHARS  = 63
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input beats
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [9:0] byte_offset, [17:10] byte_value, [23:18] zero
	input  logic [dnsdec_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] kind
	input  logic                                   s_axis_tuser,
	// result beats
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [7:0] name_char, [18:8] consumed, [20:19] status, [23:21] zero
	output logic [dnsdec_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [0] has_char
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast,
	// configuration write
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dnsdec_pkg::JUMP_W-1:0]          cfg_data
);

	localparam int AW  = $clog2(STORE_BYTES);
	localparam int NCW = $clog2(NAME_CHARS + 1);
	localparam int PW  = dnsdec_pkg::POS_W;
	localparam logic [PW-1:0]  STORE_LIM = PW'(STORE_BYTES);
	localparam logic [NCW-1:0] NAME_LIM  = NCW'(NAME_CHARS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LEN,
		ST_PTR,
		ST_LBL,
		ST_FIN
	} state_t;

	// control and walk state
	state_t                                state_q, state_d;
	logic [PW-1:0]                         pos_q, pos_d;
	logic [dnsdec_pkg::LABEL_W-1:0]        cnt_q, cnt_d;
	logic [dnsdec_pkg::LABEL_W-1:0]        hi_q, hi_d;
	logic [dnsdec_pkg::USED_W-1:0]         used_q, used_d;
	logic [dnsdec_pkg::JUMP_W-1:0]         jumps_q, jumps_d;
	logic [NCW-1:0]                        nchars_q, nchars_d;
	logic                                  jumped_q, jumped_d;
	logic                                  first_q, first_d;
	logic [dnsdec_pkg::STATUS_W-1:0]       status_q, status_d;
	logic                                  pend_valid_q, pend_valid_d;
	logic [dnsdec_pkg::BYTE_W-1:0]         pend_char_q, pend_char_d;
	logic [dnsdec_pkg::JUMP_W-1:0]         max_jumps_q;

	// output register
	logic                                  out_valid_q;
	logic                                  out_has_q;
	logic [dnsdec_pkg::BYTE_W-1:0]         out_char_q;
	logic                                  out_last_q;
	logic [dnsdec_pkg::USED_W-1:0]         out_used_q;
	logic [dnsdec_pkg::STATUS_W-1:0]       out_status_q;

	// store access
	logic [dnsdec_pkg::BYTE_W-1:0]         store_mem [STORE_BYTES];
	logic [dnsdec_pkg::BYTE_W-1:0]         rd_data_q;
	logic                                  rd_en;
	logic [PW-1:0]                         rd_pos;
	logic                                  wr_en;
	logic [PW-1:0]                         in_off;
	logic [dnsdec_pkg::BYTE_W-1:0]         in_val;

	// step helpers
	logic                                  push_ok;
	logic                                  can_emit;
	logic                                  emit_en;
	logic [dnsdec_pkg::BYTE_W-1:0]         emit_char;
	logic                                  push;
	logic                                  push_has;
	logic [dnsdec_pkg::BYTE_W-1:0]         push_char;
	logic                                  push_last;
	logic [dnsdec_pkg::USED_W-1:0]         push_used;
	logic [dnsdec_pkg::STATUS_W-1:0]       push_status;
	logic [dnsdec_pkg::USED_W-1:0]         used_nx;
	logic [PW-1:0]                         pos_p1;
	logic [PW-1:0]                         ptr_tgt;

	assign in_off = PW'(s_axis_tdata[dnsdec_pkg::OFFSET_W-1:0]);
	assign in_val = s_axis_tdata[dnsdec_pkg::OFFSET_W +: dnsdec_pkg::BYTE_W];

	assign push_ok  = !out_valid_q || m_axis_tready;
	assign can_emit = !pend_valid_q || push_ok;
	assign pos_p1   = pos_q + PW'(1);
	assign ptr_tgt  = PW'({hi_q, rd_data_q});
	assign used_nx  = (jumped_q || used_q == dnsdec_pkg::USED_MAX) ? used_q
		: used_q + dnsdec_pkg::USED_W'(1);

	// walker next-state logic
	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		cnt_d        = cnt_q;
		hi_d         = hi_q;
		used_d       = used_q;
		jumps_d      = jumps_q;
		nchars_d     = nchars_q;
		jumped_d     = jumped_q;
		first_d      = first_q;
		status_d     = status_q;
		pend_valid_d = pend_valid_q;
		pend_char_d  = pend_char_q;
		rd_en        = 1'b0;
		rd_pos       = pos_q;
		wr_en        = 1'b0;
		emit_en      = 1'b0;
		emit_char    = rd_data_q;
		push         = 1'b0;
		push_has     = pend_valid_q;
		push_char    = pend_valid_q ? pend_char_q : '0;
		push_last    = 1'b0;
		push_used    = '0;
		push_status  = dnsdec_pkg::STAT_OK;

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser == dnsdec_pkg::KIND_LOAD) begin
						wr_en = (in_off < STORE_LIM);
					end else begin
						pos_d        = in_off;
						used_d       = '0;
						jumps_d      = '0;
						nchars_d     = '0;
						jumped_d     = 1'b0;
						first_d      = 1'b1;
						status_d     = dnsdec_pkg::STAT_OK;
						pend_valid_d = 1'b0;
						state_d      = ST_FETCH;
					end
				end
			end

			// first length byte read
			ST_FETCH: begin
				if (pos_q >= STORE_LIM) begin
					status_d = dnsdec_pkg::STAT_LOOP;
					state_d  = ST_FIN;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_LEN;
				end
			end

			// length or pointer byte in rd_data_q
			ST_LEN: begin
				priority if (rd_data_q == '0) begin
					used_d  = used_nx;
					state_d = ST_FIN;
				end else if (rd_data_q >= dnsdec_pkg::PTR_MARK) begin
					used_d = used_nx;
					if (pos_p1 >= STORE_LIM) begin
						status_d = dnsdec_pkg::STAT_LOOP;
						state_d  = ST_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_pos  = pos_p1;
						pos_d   = pos_p1;
						hi_d    = rd_data_q[dnsdec_pkg::LABEL_W-1:0];
						state_d = ST_PTR;
					end
				end else if (rd_data_q >= dnsdec_pkg::RESERVED_LOW) begin
					used_d   = used_nx;
					status_d = dnsdec_pkg::STAT_RESERVED;
					state_d  = ST_FIN;
				end else if (!first_q && nchars_q >= NAME_LIM) begin
					used_d   = used_nx;
					status_d = dnsdec_pkg::STAT_TRUNC;
					state_d  = ST_FIN;
				end else if (!first_q && !can_emit) begin
					// wait for room before placing the dot
					state_d = ST_LEN;
				end else begin
					used_d    = used_nx;
					emit_en   = !first_q;
					emit_char = dnsdec_pkg::DOT_CHAR;
					first_d   = 1'b0;
					cnt_d     = rd_data_q[dnsdec_pkg::LABEL_W-1:0];
					if (pos_p1 >= STORE_LIM) begin
						status_d = dnsdec_pkg::STAT_LOOP;
						state_d  = ST_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_pos  = pos_p1;
						pos_d   = pos_p1;
						state_d = ST_LBL;
					end
				end
			end

			// second pointer byte in rd_data_q
			ST_PTR: begin
				used_d = used_nx;
				if (jumps_q >= max_jumps_q || ptr_tgt >= STORE_LIM) begin
					status_d = dnsdec_pkg::STAT_LOOP;
					state_d  = ST_FIN;
				end else begin
					jumps_d  = jumps_q + dnsdec_pkg::JUMP_W'(1);
					jumped_d = 1'b1;
					rd_en    = 1'b1;
					rd_pos   = ptr_tgt;
					pos_d    = ptr_tgt;
					state_d  = ST_LEN;
				end
			end

			// label byte in rd_data_q, next byte read in the same cycle
			ST_LBL: begin
				if (nchars_q >= NAME_LIM) begin
					used_d   = used_nx;
					status_d = dnsdec_pkg::STAT_TRUNC;
					state_d  = ST_FIN;
				end else if (can_emit) begin
					used_d  = used_nx;
					emit_en = 1'b1;
					cnt_d   = cnt_q - dnsdec_pkg::LABEL_W'(1);
					if (pos_p1 >= STORE_LIM) begin
						status_d = dnsdec_pkg::STAT_LOOP;
						state_d  = ST_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_pos  = pos_p1;
						pos_d   = pos_p1;
						state_d = (cnt_q == dnsdec_pkg::LABEL_W'(1)) ? ST_LEN : ST_LBL;
					end
				end
			end

			// final beat with consumed and status
			ST_FIN: begin
				if (push_ok) begin
					push         = 1'b1;
					push_last    = 1'b1;
					push_used    = used_q;
					push_status  = status_q;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase

		// a new character pushes the held one out
		if (emit_en) begin
			push         = pend_valid_q;
			pend_valid_d = 1'b1;
			pend_char_d  = emit_char;
			nchars_d     = nchars_q + NCW'(1);
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			max_jumps_q  <= dnsdec_pkg::JUMPS_RESET;
			pos_q        <= '0;
			cnt_q        <= '0;
			hi_q         <= '0;
			used_q       <= '0;
			jumps_q      <= '0;
			nchars_q     <= '0;
			jumped_q     <= 1'b0;
			first_q      <= 1'b1;
			status_q     <= dnsdec_pkg::STAT_OK;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			pos_q        <= pos_d;
			cnt_q        <= cnt_d;
			hi_q         <= hi_d;
			used_q       <= used_d;
			jumps_q      <= jumps_d;
			nchars_q     <= nchars_d;
			jumped_q     <= jumped_d;
			first_q      <= first_d;
			status_q     <= status_d;
			if (cfg_valid) begin
				max_jumps_q <= cfg_data;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pend_char_q <= pend_char_d;
		if (push) begin
			out_has_q    <= push_has;
			out_char_q   <= push_char;
			out_last_q   <= push_last;
			out_used_q   <= push_used;
			out_status_q <= push_status;
		end
	end

	// packet store, one port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[AW'(in_off)] <= in_val;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_pos[AW-1:0]];
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {3'b000, out_status_q, out_used_q, out_char_q};

	// checks
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held character left over after a decode");

	a_name_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nchars_q <= NAME_LIM)
		else $error("name character count past its limit");

	a_fin_sends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && push_ok) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("decode ended without a last beat");

endmodule
